// File: sv/qri_pkg.sv
// Types, constants and helper functions shared by the quaternion rate integrator.
package qri_pkg;

    localparam logic [37:0] TWO_PI_Q30 = 38'd6746518852;
    localparam logic signed [35:0] S_TWO_PI = 36'sd6746518852;
    localparam logic signed [35:0] S_PI = 36'sd3373259426;
    localparam logic signed [35:0] S_HALF_PI = 36'sd1686629713;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd1073741824;

    localparam logic [30:0] ATAN_Q30 [32] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
        31'd67021686, 31'd33543515, 31'd16775850, 31'd8388437,
        31'd4194282, 31'd2097149, 31'd1048575, 31'd524287,
        31'd262143, 31'd131071, 31'd65535, 31'd32767,
        31'd16383, 31'd8191, 31'd4095, 31'd2047,
        31'd1023, 31'd511, 31'd255, 31'd127,
        31'd63, 31'd31, 31'd15, 31'd7,
        31'd3, 31'd1, 31'd0, 31'd0
    };

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [23:0] rate_x;
        logic signed [23:0] rate_y;
        logic signed [23:0] rate_z;
        logic [23:0]        time_step;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_w;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               degenerate;
    } t_out;

    // control and payload that travels alongside every pipeline stage
    typedef struct packed {
        logic              valid;
        logic              zero;
        logic [3:0][15:0]  q;
        logic [2:0]        rneg;
        logic [2:0][23:0]  rmag;
        logic [23:0]       dt;
        logic [31:0]       nrm;
        logic [2:0][30:0]  axm;
        logic              degen;
        logic [3:0]        psgn;
        logic [3:0][29:0]  m;
    } t_side;

    typedef struct packed {
        logic [63:0] x;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [31:0]       div;
        logic [3:0][31:0]  rem;
        logic [3:0][61:0]  num;
        logic [3:0][30:0]  quot;
    } t_div;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] th;
        logic               neg;
    } t_cordic;

    function automatic logic [15:0] sat16(input logic neg, input logic [30:0] mg);
        logic [15:0] v;
        if (neg) begin
            v = (mg > 31'd32768) ? 16'h8000 : (~mg[15:0] + 16'd1);
        end else begin
            v = (mg > 31'd32767) ? 16'h7FFF : mg[15:0];
        end
        return v;
    endfunction

endpackage

// File: sv/qri_sqrt_cell.sv
// One digit-recurrence step of the integer square root chain.
module qri_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  qri_pkg::t_side    i_side,
    input  qri_pkg::t_sqrt    i_data,
    output qri_pkg::t_side    o_side,
    output qri_pkg::t_sqrt    o_data
);
    qri_pkg::t_side r_side;
    qri_pkg::t_sqrt r_data;
    qri_pkg::t_sqrt n_data;
    logic [35:0] w_rem;
    logic [35:0] w_trial;

    always_comb begin
        w_rem   = {i_data.rem, i_data.x[63:62]};
        w_trial = {2'b00, i_data.root, 2'b01};
        n_data.x = {i_data.x[61:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_data.rem  = 34'(w_rem - w_trial);
            n_data.root = {i_data.root[30:0], 1'b1};
        end else begin
            n_data.rem  = w_rem[33:0];
            n_data.root = {i_data.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_data <= n_data;
        end
    end

    assign o_side = r_side;
    assign o_data = r_data;
endmodule

// File: sv/qri_div_cell.sv
// One restoring-division step for four lanes sharing a divisor.
module qri_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  qri_pkg::t_side   i_side,
    input  qri_pkg::t_div    i_data,
    output qri_pkg::t_side   o_side,
    output qri_pkg::t_div    o_data
);
    qri_pkg::t_side r_side;
    qri_pkg::t_div  r_data;
    qri_pkg::t_div  n_data;
    logic [32:0] w_r [4];

    always_comb begin
        n_data.div = i_data.div;
        for (int l = 0; l < 4; l++) begin
            w_r[l] = {i_data.rem[l], i_data.num[l][61]};
            n_data.num[l] = {i_data.num[l][60:0], 1'b0};
            if (w_r[l] >= {1'b0, i_data.div}) begin
                n_data.rem[l]  = 32'(w_r[l] - {1'b0, i_data.div});
                n_data.quot[l] = {i_data.quot[l][29:0], 1'b1};
            end else begin
                n_data.rem[l]  = w_r[l][31:0];
                n_data.quot[l] = {i_data.quot[l][29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_data <= n_data;
        end
    end

    assign o_side = r_side;
    assign o_data = r_data;
endmodule

// File: sv/qri_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation.
module qri_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  qri_pkg::t_side     i_side,
    input  qri_pkg::t_cordic   i_data,
    output qri_pkg::t_side     o_side,
    output qri_pkg::t_cordic   o_data
);
    localparam logic signed [33:0] ANG = $signed({3'b000, qri_pkg::ATAN_Q30[STAGE]});

    qri_pkg::t_side   r_side;
    qri_pkg::t_cordic r_data;
    qri_pkg::t_cordic n_data;
    logic signed [33:0] w_xs;
    logic signed [33:0] w_ys;

    always_comb begin
        w_xs = i_data.x >>> STAGE;
        w_ys = i_data.y >>> STAGE;
        n_data.neg = i_data.neg;
        if (!i_data.th[33]) begin
            n_data.x  = i_data.x - w_ys;
            n_data.y  = i_data.y + w_xs;
            n_data.th = i_data.th - ANG;
        end else begin
            n_data.x  = i_data.x + w_ys;
            n_data.y  = i_data.y - w_xs;
            n_data.th = i_data.th + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_data <= n_data;
        end
    end

    assign o_side = r_side;
    assign o_data = r_data;
endmodule

// File: sv/quaternion_rate_integrator.sv
// Top level: gyro rate integration of an attitude quaternion, fully pipelined.
//
//  channel  direction  valid         stall         payload
//  input    in         i_in_valid    o_in_stall    i_in_item  (qri_pkg::t_in)
//  output   out        o_out_valid   i_out_stall   o_out_item (qri_pkg::t_out)
//
// One item per cycle while the output is not stalled; the latency is set by the
// two 32-step square root chains, the 31-step axis divider chain,
// the CORDIC chain and the normalizing divider chain.
// Reset clears the valid bit of every stage.
// When the output item is stalled, the whole pipeline holds and o_in_stall rises.
module quaternion_rate_integrator #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int CORDIC_STAGES  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  qri_pkg::t_in    i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output qri_pkg::t_out   o_out_item
);
    localparam int NDIV = QUAT_FRAC_BITS + 1;
    localparam logic [15:0] ONE_W =
        (QUAT_FRAC_BITS >= 15) ? 16'h7FFF : 16'(1 << QUAT_FRAC_BITS);

    logic w_en;
    logic r_out_valid;
    qri_pkg::t_out r_out_item;
    qri_pkg::t_out n_out_item;

    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // input capture and rate squares
    qri_pkg::t_side r_s1, n_s1;
    logic [47:0] r_sq [3];
    logic [47:0] n_sq [3];

    always_comb begin
        n_s1 = '0;
        n_s1.valid = i_in_valid;
        n_s1.q[0] = i_in_item.quat_w;
        n_s1.q[1] = i_in_item.quat_x;
        n_s1.q[2] = i_in_item.quat_y;
        n_s1.q[3] = i_in_item.quat_z;
        n_s1.rneg[0] = i_in_item.rate_x[23];
        n_s1.rneg[1] = i_in_item.rate_y[23];
        n_s1.rneg[2] = i_in_item.rate_z[23];
        n_s1.rmag[0] = i_in_item.rate_x[23] ? 24'(-i_in_item.rate_x) : i_in_item.rate_x;
        n_s1.rmag[1] = i_in_item.rate_y[23] ? 24'(-i_in_item.rate_y) : i_in_item.rate_y;
        n_s1.rmag[2] = i_in_item.rate_z[23] ? 24'(-i_in_item.rate_z) : i_in_item.rate_z;
        n_s1.dt = i_in_item.time_step;
        for (int k = 0; k < 3; k++) begin
            n_sq[k] = {24'd0, n_s1.rmag[k]} * {24'd0, n_s1.rmag[k]};
        end
    end

    // sum of squares
    qri_pkg::t_side r_s2, n_s2;
    logic [47:0] r_sumsq, n_sumsq;

    always_comb begin
        n_sumsq = r_sq[0] + r_sq[1] + r_sq[2];
        n_s2 = r_s1;
        n_s2.zero = (n_sumsq == 48'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (w_en) begin
            r_s1 <= n_s1;
            r_sq <= n_sq;
            r_s2 <= n_s2;
            r_sumsq <= n_sumsq;
        end
    end

    // rate norm
    qri_pkg::t_side sa_side [33];
    qri_pkg::t_sqrt sa_data [33];

    assign sa_side[0] = r_s2;
    assign sa_data[0] = '{x: {r_sumsq, 16'd0}, rem: 34'd0, root: 32'd0};

    for (genvar g = 0; g < 32; g++) begin : g_sqrt_a
        qri_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_side(sa_side[g]), .i_data(sa_data[g]),
            .o_side(sa_side[g+1]), .o_data(sa_data[g+1])
        );
    end

    // axis: |r| * 2^38 / N
    qri_pkg::t_side da_side [32];
    qri_pkg::t_div  da_data [32];

    always_comb begin
        da_side[0] = sa_side[32];
        da_side[0].nrm = sa_data[32].root;
        da_data[0] = '0;
        da_data[0].div = sa_data[32].root;
        for (int l = 0; l < 3; l++) begin
            da_data[0].rem[l] = {1'b0, sa_side[32].rmag[l], 7'd0};
        end
    end

    for (genvar g = 0; g < 31; g++) begin : g_div_a
        qri_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_side(da_side[g]), .i_data(da_data[g]),
            .o_side(da_side[g+1]), .o_data(da_data[g+1])
        );
    end

    // half angle
    qri_pkg::t_side r_s3, n_s3;
    logic [55:0] r_prod;

    always_comb begin
        n_s3 = da_side[31];
        for (int l = 0; l < 3; l++) begin
            n_s3.axm[l] = da_data[31].quot[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (w_en) begin
            r_s3 <= n_s3;
            r_prod <= {24'd0, n_s3.nrm} * {32'd0, n_s3.dt};
        end
    end

    // modulo 2pi by conditional subtraction of 2pi * 16, 8, 4, 2, 1
    qri_pkg::t_side md_side [6];
    logic [36:0]    md_h [6];

    assign md_side[0] = r_s3;
    assign md_h[0]    = r_prod[55:19];

    for (genvar g = 0; g < 5; g++) begin : g_mod
        localparam logic [37:0] SUB = qri_pkg::TWO_PI_Q30 << (4 - g);
        qri_pkg::t_side r_side;
        logic [36:0]    r_h;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side.valid <= 1'b0;
            end else if (w_en) begin
                r_side <= md_side[g];
                r_h <= ({1'b0, md_h[g]} >= SUB) ? 37'({1'b0, md_h[g]} - SUB) : md_h[g];
            end
        end
        assign md_side[g+1] = r_side;
        assign md_h[g+1]    = r_h;
    end

    // fold into [-pi/2, pi/2]
    qri_pkg::t_side   r_s4;
    qri_pkg::t_cordic r_cd, n_cd;
    logic signed [35:0] w_th;

    always_comb begin
        w_th = $signed({3'b000, md_h[5][32:0]});
        if (w_th > qri_pkg::S_PI) begin
            w_th = w_th - qri_pkg::S_TWO_PI;
        end
        n_cd.neg = 1'b0;
        if (w_th > qri_pkg::S_HALF_PI) begin
            w_th = w_th - qri_pkg::S_PI;
            n_cd.neg = 1'b1;
        end else if (w_th < -qri_pkg::S_HALF_PI) begin
            w_th = w_th + qri_pkg::S_PI;
            n_cd.neg = 1'b1;
        end
        n_cd.th = w_th[33:0];
        n_cd.x  = qri_pkg::CORDIC_X0;
        n_cd.y  = 34'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
        end else if (w_en) begin
            r_s4 <= md_side[5];
            r_cd <= n_cd;
        end
    end

    // sine and cosine of the half angle
    qri_pkg::t_side   cd_side [CORDIC_STAGES+1];
    qri_pkg::t_cordic cd_data [CORDIC_STAGES+1];

    assign cd_side[0] = r_s4;
    assign cd_data[0] = r_cd;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        qri_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_side(cd_side[g]), .i_data(cd_data[g]),
            .o_side(cd_side[g+1]), .o_data(cd_data[g+1])
        );
    end

    // delta quaternion
    qri_pkg::t_side r_s5;
    logic signed [33:0] r_dq [4];
    logic signed [33:0] n_dq [4];
    logic signed [33:0] w_c, w_s;
    logic signed [31:0] w_ax [3];
    logic signed [65:0] w_pr [3];

    always_comb begin
        w_c = cd_data[CORDIC_STAGES].neg ? -cd_data[CORDIC_STAGES].x
                                         : cd_data[CORDIC_STAGES].x;
        w_s = cd_data[CORDIC_STAGES].neg ? -cd_data[CORDIC_STAGES].y
                                         : cd_data[CORDIC_STAGES].y;
        n_dq[0] = w_c;
        for (int l = 0; l < 3; l++) begin
            w_ax[l] = cd_side[CORDIC_STAGES].rneg[l]
                    ? -$signed({1'b0, cd_side[CORDIC_STAGES].axm[l]})
                    :  $signed({1'b0, cd_side[CORDIC_STAGES].axm[l]});
            w_pr[l] = 66'(w_ax[l]) * 66'(w_s);
            n_dq[l+1] = w_pr[l][63:30];
        end
    end

    // Hamilton product: partial products, then sums
    qri_pkg::t_side r_s6, r_s7;
    logic signed [49:0] r_pp [4][4];
    logic signed [49:0] r_p [4];
    logic signed [49:0] n_p [4];

    always_comb begin
        n_p[0] = r_pp[0][0] - r_pp[1][1] - r_pp[2][2] - r_pp[3][3];
        n_p[1] = r_pp[0][1] + r_pp[1][0] + r_pp[2][3] - r_pp[3][2];
        n_p[2] = r_pp[0][2] - r_pp[1][3] + r_pp[2][0] + r_pp[3][1];
        n_p[3] = r_pp[0][3] + r_pp[1][2] - r_pp[2][1] + r_pp[3][0];
        if (r_s6.zero) begin
            for (int a = 0; a < 4; a++) begin
                n_p[a] = 50'($signed(r_s6.q[a]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.valid <= 1'b0;
            r_s6.valid <= 1'b0;
            r_s7.valid <= 1'b0;
        end else if (w_en) begin
            r_s5 <= cd_side[CORDIC_STAGES];
            r_dq <= n_dq;
            r_s6 <= r_s5;
            for (int a = 0; a < 4; a++) begin
                for (int b = 0; b < 4; b++) begin
                    r_pp[a][b] <= 50'($signed(r_s5.q[a])) * 50'(r_dq[b]);
                end
            end
            r_s7 <= r_s6;
            r_p <= n_p;
        end
    end

    // normalization: leading bit, block shift, squares, sum
    qri_pkg::t_side r_s8, n_s8, r_s9, n_s9, r_s10, r_s11;
    logic [49:0] r_mag [4];
    logic [49:0] n_mag [4];
    logic [49:0] w_or;
    logic [5:0]  w_lead;
    logic        r_rsh, n_rsh;
    logic [5:0]  r_amt, n_amt;
    logic [59:0] r_msq [4];
    logic [61:0] r_sum;

    always_comb begin
        n_s8 = r_s7;
        w_or = '0;
        for (int a = 0; a < 4; a++) begin
            n_mag[a] = r_p[a][49] ? 50'(-r_p[a]) : 50'(r_p[a]);
            n_s8.psgn[a] = r_p[a][49];
            w_or = w_or | n_mag[a];
        end
        n_s8.degen = (w_or == 50'd0);
        w_lead = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (w_or[i]) begin
                w_lead = 6'(i);
            end
        end
        n_rsh = (w_lead >= 6'd29);
        n_amt = n_rsh ? 6'(w_lead - 6'd29) : 6'(6'd29 - w_lead);
    end

    always_comb begin
        n_s9 = r_s8;
        for (int a = 0; a < 4; a++) begin
            n_s9.m[a] = r_rsh ? 30'(r_mag[a] >> r_amt) : 30'(r_mag[a] << r_amt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8.valid <= 1'b0;
            r_s9.valid <= 1'b0;
            r_s10.valid <= 1'b0;
            r_s11.valid <= 1'b0;
        end else if (w_en) begin
            r_s8 <= n_s8;
            r_mag <= n_mag;
            r_rsh <= n_rsh;
            r_amt <= n_amt;
            r_s9 <= n_s9;
            r_s10 <= r_s9;
            for (int a = 0; a < 4; a++) begin
                r_msq[a] <= {30'd0, r_s9.m[a]} * {30'd0, r_s9.m[a]};
            end
            r_s11 <= r_s10;
            r_sum <= 62'(r_msq[0]) + 62'(r_msq[1]) + 62'(r_msq[2]) + 62'(r_msq[3]);
        end
    end

    qri_pkg::t_side sb_side [33];
    qri_pkg::t_sqrt sb_data [33];

    assign sb_side[0] = r_s11;
    assign sb_data[0] = '{x: {2'b00, r_sum}, rem: 34'd0, root: 32'd0};

    for (genvar g = 0; g < 32; g++) begin : g_sqrt_b
        qri_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_side(sb_side[g]), .i_data(sb_data[g]),
            .o_side(sb_side[g+1]), .o_data(sb_data[g+1])
        );
    end

    // rounded division of each magnitude by the norm
    qri_pkg::t_side db_side [NDIV+1];
    qri_pkg::t_div  db_data [NDIV+1];
    logic [61:0]    w_num [4];

    always_comb begin
        db_side[0] = sb_side[32];
        db_data[0] = '0;
        db_data[0].div = sb_data[32].root;
        for (int l = 0; l < 4; l++) begin
            w_num[l] = (62'(sb_side[32].m[l]) << QUAT_FRAC_BITS)
                     + 62'(sb_data[32].root >> 1);
            db_data[0].rem[l] = 32'(w_num[l] >> NDIV);
            db_data[0].num[l] = w_num[l] << (62 - NDIV);
        end
    end

    for (genvar g = 0; g < NDIV; g++) begin : g_div_b
        qri_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_side(db_side[g]), .i_data(db_data[g]),
            .o_side(db_side[g+1]), .o_data(db_data[g+1])
        );
    end

    always_comb begin
        if (db_side[NDIV].degen) begin
            n_out_item.out_w = ONE_W;
            n_out_item.out_x = 16'sd0;
            n_out_item.out_y = 16'sd0;
            n_out_item.out_z = 16'sd0;
            n_out_item.degenerate = 1'b1;
        end else begin
            n_out_item.out_w = qri_pkg::sat16(db_side[NDIV].psgn[0], db_data[NDIV].quot[0]);
            n_out_item.out_x = qri_pkg::sat16(db_side[NDIV].psgn[1], db_data[NDIV].quot[1]);
            n_out_item.out_y = qri_pkg::sat16(db_side[NDIV].psgn[2], db_data[NDIV].quot[2]);
            n_out_item.out_z = qri_pkg::sat16(db_side[NDIV].psgn[3], db_data[NDIV].quot[3]);
            n_out_item.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= db_side[NDIV].valid;
            r_out_item <= n_out_item;
        end
    end
endmodule

// File: sv/qri_checker.sv
// Port-level checks for the quaternion rate integrator, bound to the top level.
module qri_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input qri_pkg::t_in    i_in_item,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input qri_pkg::t_out   o_out_item
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    a_degen_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.degenerate) |->
        (o_out_item.out_x == 16'sd0 && o_out_item.out_y == 16'sd0
         && o_out_item.out_z == 16'sd0))
        else $error("degenerate item is not identity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled output item changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_item)))
        else $error("stalled input item changed");
endmodule

bind quaternion_rate_integrator qri_checker u_qri_checker (.*);
